// ===== sv/mbtcp_pkg.sv =====
// Package for the Modbus TCP frame recognizer.
// Holds shared widths, protocol constants and the verdict flag struct.
// No dependencies.
package mbtcp_pkg;

  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int RS_BITS               = 17;  // record start offset
  localparam int COUNT_BITS            = 13;
  localparam int SIZE_BITS             = 16;
  localparam int HDR_STORED            = 8;   // header bytes kept; the ninth is the live byte

  localparam logic [15:0] MAX_FIRST_PACKET_RESET = 16'd260;
  localparam logic [15:0] LDAP_TID_MASK          = 16'hFF80;
  localparam logic [15:0] LDAP_TID_MATCH         = 16'h3080;
  localparam logic [7:0]  PROBE_OFFSET           = 8'd2;
  localparam logic [7:0]  BER_INTEGER_TAG        = 8'h02;
  localparam logic [7:0]  FUNC_CODE_MAX          = 8'd127;
  localparam logic [7:0]  EXC_CODE_MAX           = 8'd12;
  localparam logic [15:0] MBAP_OVERHEAD          = 16'd6;
  localparam logic [15:0] MIN_MBAP_LENGTH        = 16'd3;
  localparam logic [15:0] CHECK_BYTES            = 16'd9;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;

  typedef struct packed {
    logic rejected;
    logic stopped;
    logic probe;
  } mbtcp_flags_t;

endpackage

// ===== sv/mbtcp_step.sv =====
// Per-byte next-state logic of the MBAP header walk (combinational).
// Depends on mbtcp_pkg.
module mbtcp_step #(
  parameter int POSITION_BITS = mbtcp_pkg::POSITION_BITS_DEFAULT
) (
  input  logic [7:0]                       payload_byte,
  input  logic                             is_last,
  input  logic [mbtcp_pkg::SIZE_BITS-1:0]  payload_size,
  input  logic [mbtcp_pkg::SIZE_BITS-1:0]  first_packet_length,
  input  logic                             is_tcp,
  input  logic [15:0]                      max_first_packet_bytes,
  input  logic [POSITION_BITS-1:0]         byte_position,
  input  logic [mbtcp_pkg::RS_BITS-1:0]    record_start,
  input  logic [7:0]                       hdr [mbtcp_pkg::HDR_STORED],
  input  logic [7:0]                       probe_index,
  input  logic [mbtcp_pkg::COUNT_BITS-1:0] valid_records,
  input  mbtcp_pkg::mbtcp_flags_t          flags,
  output logic [POSITION_BITS-1:0]         byte_position_next,
  output logic [mbtcp_pkg::RS_BITS-1:0]    record_start_next,
  output logic [7:0]                       hdr_next [mbtcp_pkg::HDR_STORED],
  output logic [7:0]                       probe_index_next,
  output logic [mbtcp_pkg::COUNT_BITS-1:0] valid_records_next,
  output mbtcp_pkg::mbtcp_flags_t          flags_next,
  output logic                             recognized,
  output logic [mbtcp_pkg::COUNT_BITS-1:0] record_count
);

  localparam int PW = (POSITION_BITS > mbtcp_pkg::RS_BITS) ? POSITION_BITS : mbtcp_pkg::RS_BITS;
  localparam int W  = PW + 2;

  logic [W-1:0]  pos_w;
  logic [W-1:0]  rs_w;
  logic [W-1:0]  offset;
  logic [15:0]   tid;
  logic [15:0]   prot;
  logic [15:0]   len;
  logic [7:0]    func;
  logic [W-1:0]  rec_end;
  logic [16:0]   len_plus;
  logic          in_hdr;
  logic          is_check;
  logic          ok;

  always_comb begin
    pos_w  = W'(byte_position);
    rs_w   = W'(record_start);
    offset = pos_w - rs_w;

    flags_next         = flags;
    probe_index_next   = probe_index;
    valid_records_next = valid_records;
    record_start_next  = record_start;
    hdr_next           = hdr;

    // capture header bytes of the record being walked
    in_hdr = !flags.stopped && (pos_w >= rs_w) && (offset < W'(mbtcp_pkg::HDR_STORED));
    if (in_hdr) begin
      hdr_next[offset[2:0]] = payload_byte;
    end

    tid      = {hdr_next[0], hdr_next[1]};
    prot     = {hdr_next[2], hdr_next[3]};
    len      = {hdr_next[4], hdr_next[5]};
    func     = hdr_next[7];
    len_plus = 17'(len) + 17'(mbtcp_pkg::MBAP_OVERHEAD);
    rec_end  = rs_w + W'(len_plus);

    // LDAP lookalike probe fires on its byte
    if (flags.probe && pos_w == W'(probe_index)) begin
      if (16'(probe_index) < payload_size && payload_byte == mbtcp_pkg::BER_INTEGER_TAG) begin
        flags_next.rejected = 1'b1;
      end
      flags_next.probe = 1'b0;
    end

    // arm the probe on byte 1 of the first record
    if (pos_w == W'(1) && record_start == '0 && !flags.stopped &&
        (tid & mbtcp_pkg::LDAP_TID_MASK) == mbtcp_pkg::LDAP_TID_MATCH) begin
      probe_index_next = {1'b0, tid[6:0]} + mbtcp_pkg::PROBE_OFFSET;
      flags_next.probe = 1'b1;
    end

    // record check on the ninth byte (the live byte is the exception code)
    is_check = !flags.stopped && (pos_w == rs_w + W'(8));
    if (is_check) begin
      if (rs_w + W'(mbtcp_pkg::CHECK_BYTES) > W'(payload_size)) begin
        flags_next.stopped = 1'b1;
      end else if (tid == first_packet_length) begin
        flags_next.rejected = 1'b1;
        flags_next.stopped  = 1'b1;
      end else if (prot != 16'd0 || len < mbtcp_pkg::MIN_MBAP_LENGTH ||
                   rec_end > W'(payload_size)) begin
        flags_next.stopped = 1'b1;
      end else if (valid_records == '0 && len_plus != 17'(first_packet_length)) begin
        flags_next.rejected = 1'b1;
        flags_next.stopped  = 1'b1;
      end else if (func > mbtcp_pkg::FUNC_CODE_MAX &&
                   (payload_byte == 8'd0 || payload_byte > mbtcp_pkg::EXC_CODE_MAX)) begin
        flags_next.stopped = 1'b1;
      end else begin
        if (valid_records != mbtcp_pkg::COUNT_MAX) begin
          valid_records_next = valid_records + 1'b1;
        end
        record_start_next = rec_end[mbtcp_pkg::RS_BITS-1:0];
      end
    end

    byte_position_next = (byte_position != '1) ? byte_position + 1'b1 : byte_position;

    ok = !flags_next.rejected && is_tcp && (payload_size >= mbtcp_pkg::CHECK_BYTES) &&
         (first_packet_length <= max_first_packet_bytes) && (valid_records_next != '0);
    recognized   = ok;
    record_count = ok ? valid_records_next : '0;

    // end of payload: back to the reset state
    if (is_last) begin
      byte_position_next = '0;
      record_start_next  = '0;
      probe_index_next   = '0;
      valid_records_next = '0;
      flags_next         = '0;
    end
  end

endmodule

// ===== sv/modbus_tcp_frame_recognizer_top.sv =====
// Top level of the Modbus TCP frame recognizer: input register, walk state,
// result register. Depends on mbtcp_pkg and mbtcp_step.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one payload byte per
//   transaction with its payload size, first packet length, TCP flag and a
//   last-byte mark. Output channel (out_valid / out_stall) carries one
//   transaction per payload, on its last byte: recognized and record_count
//   (record_count is 0 when recognized is 0).
//   Path: an accepted byte is captured in the input register and walked from
//   there; the verdict of a last byte is captured in the result register.
//   Throughput: one byte per cycle while no last byte is held (see Stall);
//   the walk update between input and result register is combinational.
//   Stall: only a last byte is ever held in the input register. It waits
//   there while an earlier verdict is still held and out_stall is high;
//   in_stall is raised meanwhile, so the next byte waits at the input.
//   cfg_we / cfg_wdata write max_first_packet_bytes; write it only while
//   no payload is in flight.
//   Reset (rst, synchronous): clears the walk state but the header bytes,
//   empties both registers, sets max_first_packet_bytes to 260.
module modbus_tcp_frame_recognizer_top #(
  parameter int POSITION_BITS = mbtcp_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       payload_byte,
  input  logic                             is_last,
  input  logic [mbtcp_pkg::SIZE_BITS-1:0]  payload_size,
  input  logic [mbtcp_pkg::SIZE_BITS-1:0]  first_packet_length,
  input  logic                             is_tcp,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             recognized,
  output logic [mbtcp_pkg::COUNT_BITS-1:0] record_count,
  input  logic                             cfg_we,
  input  logic [15:0]                      cfg_wdata
);

  // configuration
  logic [15:0] max_first_packet_bytes;

  // input register
  logic                            s1_valid;
  logic [7:0]                      s1_byte;
  logic                            s1_last;
  logic [mbtcp_pkg::SIZE_BITS-1:0] s1_size;
  logic [mbtcp_pkg::SIZE_BITS-1:0] s1_fpl;
  logic                            s1_tcp;
  logic                            s1_go;

  // walk state
  logic [POSITION_BITS-1:0]         byte_position, byte_position_next;
  logic [mbtcp_pkg::RS_BITS-1:0]    record_start, record_start_next;
  logic [7:0]                       hdr [mbtcp_pkg::HDR_STORED];
  logic [7:0]                       hdr_next [mbtcp_pkg::HDR_STORED];
  logic [7:0]                       probe_index, probe_index_next;
  logic [mbtcp_pkg::COUNT_BITS-1:0] valid_records, valid_records_next;
  mbtcp_pkg::mbtcp_flags_t          flags, flags_next;
  logic                             recognized_next;
  logic [mbtcp_pkg::COUNT_BITS-1:0] record_count_next;

  // a byte moves on unless it is a last byte blocked by a held verdict
  assign s1_go    = s1_valid && (!s1_last || !out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_first_packet_bytes <= mbtcp_pkg::MAX_FIRST_PACKET_RESET;
    end else if (cfg_we) begin
      max_first_packet_bytes <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= payload_byte;
      s1_last <= is_last;
      s1_size <= payload_size;
      s1_fpl  <= first_packet_length;
      s1_tcp  <= is_tcp;
    end
  end

  mbtcp_step #(
    .POSITION_BITS(POSITION_BITS)
  ) u_step (
    .payload_byte          (s1_byte),
    .is_last               (s1_last),
    .payload_size          (s1_size),
    .first_packet_length   (s1_fpl),
    .is_tcp                (s1_tcp),
    .max_first_packet_bytes(max_first_packet_bytes),
    .byte_position         (byte_position),
    .record_start          (record_start),
    .hdr                   (hdr),
    .probe_index           (probe_index),
    .valid_records         (valid_records),
    .flags                 (flags),
    .byte_position_next    (byte_position_next),
    .record_start_next     (record_start_next),
    .hdr_next              (hdr_next),
    .probe_index_next      (probe_index_next),
    .valid_records_next    (valid_records_next),
    .flags_next            (flags_next),
    .recognized            (recognized_next),
    .record_count          (record_count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      record_start  <= '0;
      probe_index   <= '0;
      valid_records <= '0;
      flags         <= '0;
    end else if (s1_go) begin
      byte_position <= byte_position_next;
      record_start  <= record_start_next;
      probe_index   <= probe_index_next;
      valid_records <= valid_records_next;
      flags         <= flags_next;
    end
  end

  // header bytes are always written before they are read within a payload
  always_ff @(posedge clk) begin
    if (s1_go) begin
      hdr <= hdr_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      recognized   <= recognized_next;
      record_count <= record_count_next;
    end
  end

`ifndef SYNTHESIS
  a_count_zero_when_refused: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !recognized) |-> record_count == '0)
    else $error("record_count nonzero on a refused payload");

  a_count_nonzero_when_recognized: assert property (@(posedge clk) disable iff (rst)
    (out_valid && recognized) |-> record_count != '0)
    else $error("recognized payload with no records");

  a_state_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (s1_go && s1_last) |=> (byte_position == '0 && valid_records == '0 &&
                            record_start == '0 && flags == '0))
    else $error("walk state not cleared after the last byte");

  a_stall_only_on_held_last: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_last && out_valid && out_stall))
    else $error("input stalled without a blocked last byte");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for modbus_tcp_frame_recognizer_top: directed payload
// table, then random Modbus/lookalike/noise payloads under several limits.
// Depends on mbtcp_pkg and the recognizer RTL.
module tb_top;

  // Probe index comes from the low seven bits of the transaction id.
  localparam int unsigned PROBE_LEN_MASK = 'h7F;
  // Idle edges after the last verdict before the block counts as empty.
  localparam int SETTLE_CYCLES = 4;
  localparam int STUCK_LIMIT = 1000;
  localparam int PIN_SLOTS = 32;
  localparam int PHASE_BYTES = 200;

  typedef struct packed {
    logic                             recognized;
    logic [mbtcp_pkg::COUNT_BITS-1:0] records;
  } verdict_t;

  // One directed payload: bytes right-aligned, first byte most significant.
  typedef struct {
    int          n;
    logic [159:0] bytes;
    logic [15:0] size;
    logic [15:0] fpl;
    logic        tcp;
    bit          pinned;
    verdict_t    want;
  } dir_row_t;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             in_valid;
  logic                             in_stall;
  logic [7:0]                       payload_byte;
  logic                             is_last;
  logic [mbtcp_pkg::SIZE_BITS-1:0]  payload_size;
  logic [mbtcp_pkg::SIZE_BITS-1:0]  first_packet_length;
  logic                             is_tcp;
  logic                             out_valid;
  logic                             out_stall = 1'b1;
  logic                             recognized;
  logic [mbtcp_pkg::COUNT_BITS-1:0] record_count;
  logic                             cfg_we;
  logic [15:0]                      cfg_wdata;

  modbus_tcp_frame_recognizer_top uut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .payload_byte        (payload_byte),
    .is_last             (is_last),
    .payload_size        (payload_size),
    .first_packet_length (first_packet_length),
    .is_tcp              (is_tcp),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .recognized          (recognized),
    .record_count        (record_count),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Walk predictor: mirrors the byte-serial MBAP walk, updated on every
  // accepted input transaction, pushes one verdict per last byte.
  // ---------------------------------------------------------------------------
  logic [15:0]                      fp_limit;      // max first packet bytes
  logic [15:0]                      w_pos;         // saturating byte index
  int unsigned                      w_rec_start;   // offset of record being walked
  logic [7:0]                       w_hdr [0:8];   // first nine bytes of that record
  int unsigned                      w_probe_at;    // byte index the LDAP probe looks at
  logic [mbtcp_pkg::COUNT_BITS-1:0] w_records;
  mbtcp_pkg::mbtcp_flags_t          wf;

  verdict_t verdicts_due[$];
  verdict_t pin_val [0:PIN_SLOTS-1];
  bit       pin_set [0:PIN_SLOTS-1];
  int       payloads_done;
  int       payloads_sent;
  int       mismatches;

  task automatic clear_walk();
    w_pos = '0;
    w_rec_start = 0;
    foreach (w_hdr[i]) w_hdr[i] = '0;
    w_probe_at = 0;
    w_records = '0;
    wf = '0;
  endtask

  // Runs on the ninth byte of a record; stops or refuses, else counts it.
  task automatic check_mbap_record();
    int unsigned tid, prot, len;
    tid = {w_hdr[0], w_hdr[1]};
    prot = {w_hdr[2], w_hdr[3]};
    len = {w_hdr[4], w_hdr[5]};
    if (w_rec_start + mbtcp_pkg::CHECK_BYTES > payload_size) begin
      wf.stopped = 1'b1;
    end else if (tid == first_packet_length) begin
      // length-prefixed lookalike
      wf.rejected = 1'b1;
      wf.stopped = 1'b1;
    end else if (prot != 0 || len < mbtcp_pkg::MIN_MBAP_LENGTH ||
                 w_rec_start + mbtcp_pkg::MBAP_OVERHEAD + len > payload_size) begin
      wf.stopped = 1'b1;
    end else if (w_records == 0 &&
                 len + mbtcp_pkg::MBAP_OVERHEAD != first_packet_length) begin
      wf.rejected = 1'b1;
      wf.stopped = 1'b1;
    end else if (w_hdr[7] > mbtcp_pkg::FUNC_CODE_MAX &&
                 (w_hdr[8] == 0 || w_hdr[8] > mbtcp_pkg::EXC_CODE_MAX)) begin
      wf.stopped = 1'b1;
    end else begin
      if (w_records != mbtcp_pkg::COUNT_MAX) w_records++;
      w_rec_start += len + mbtcp_pkg::MBAP_OVERHEAD;
    end
  endtask

  task automatic walk_byte();
    int unsigned p, tid;
    verdict_t v;
    p = w_pos;
    if (!wf.stopped && p >= w_rec_start && p - w_rec_start < mbtcp_pkg::CHECK_BYTES)
      w_hdr[p - w_rec_start] = payload_byte;
    if (wf.probe && p == w_probe_at) begin
      if (w_probe_at < payload_size && payload_byte == mbtcp_pkg::BER_INTEGER_TAG)
        wf.rejected = 1'b1;
      wf.probe = 1'b0;
    end
    if (p == 1 && w_rec_start == 0 && !wf.stopped) begin
      tid = {w_hdr[0], w_hdr[1]};
      if ((tid & mbtcp_pkg::LDAP_TID_MASK) == mbtcp_pkg::LDAP_TID_MATCH) begin
        w_probe_at = (tid & PROBE_LEN_MASK) + mbtcp_pkg::PROBE_OFFSET;
        wf.probe = 1'b1;
      end
    end
    if (!wf.stopped && p == w_rec_start + mbtcp_pkg::CHECK_BYTES - 1) check_mbap_record();
    if (w_pos != '1) w_pos++;
    if (is_last) begin
      v.recognized = !wf.rejected && is_tcp && payload_size >= mbtcp_pkg::CHECK_BYTES &&
                     first_packet_length <= fp_limit && w_records != 0;
      v.records = v.recognized ? w_records : '0;
      // directed rows with a hand-written verdict override the predictor
      if (payloads_done < PIN_SLOTS && pin_set[payloads_done]) v = pin_val[payloads_done];
      verdicts_due.push_back(v);
      payloads_done++;
      clear_walk();
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_verdict();
    verdict_t want;
    if (verdicts_due.size() == 0) begin
      report_mismatch($sformatf("verdict with none pending (recognized=%0b count=%0d)",
                                recognized, record_count));
    end else begin
      want = verdicts_due.pop_front();
      if (recognized !== want.recognized)
        report_mismatch($sformatf("recognized got %0b want %0b", recognized, want.recognized));
      if (record_count !== want.records)
        report_mismatch($sformatf("record_count got %0d want %0d", record_count, want.records));
    end
  endtask

  // Monitor: everything is sampled at the rising edge, before any NBA lands.
  // Output is checked before the input is walked so a fresh expectation can
  // never absorb a stray verdict in the same cycle.
  always @(posedge clk) begin
    if (rst) begin
      clear_walk();
      fp_limit = mbtcp_pkg::MAX_FIRST_PACKET_RESET;
    end else begin
      if (cfg_we) fp_limit = cfg_wdata;
      if (out_valid && !out_stall) check_verdict();
      if (in_valid && !in_stall) walk_byte();
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: after each verdict transaction, draw a random hold-off for the
  // next verdict. The count only runs while out_valid is high, so a drawn
  // hold-off is always spent on a waiting verdict. Calm stretches draw zero.
  // ---------------------------------------------------------------------------
  bit calm;
  int stall_left;

  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      stall_left = calm ? 0 : $urandom_range(0, 6);
      out_stall <= (stall_left != 0);
    end else if (out_valid && stall_left > 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  // Watchdog: cycles without any transaction on either channel.
  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  logic [7:0]  pl_data[$];
  logic [15:0] pl_size;
  logic [15:0] pl_fpl;
  logic        pl_tcp;
  bit          pl_jitter;   // redraw size/fpl/tcp on every byte
  int          bytes_sent;

  // Sends the payload in pl_*; valid stays up across back-to-back bytes.
  task automatic send_payload();
    int gap;
    calm = ($urandom_range(0, 4) == 0);
    payloads_sent++;
    for (int i = 0; i < pl_data.size(); i++) begin
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      payload_byte <= pl_data[i];
      is_last <= (i == pl_data.size() - 1);
      payload_size <= pl_jitter ? 16'($urandom) : pl_size;
      first_packet_length <= pl_jitter ? 16'($urandom) : pl_fpl;
      is_tcp <= pl_jitter ? 1'($urandom) : pl_tcp;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      bytes_sent++;
    end
  endtask

  // Hold off until every verdict is in and the walk pipeline has emptied.
  // The first edge lets the monitor log the last accepted byte.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_fp_limit(input logic [15:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_u16(input logic [15:0] v);
    pl_data.push_back(v[15:8]);
    pl_data.push_back(v[7:0]);
  endtask

  // Random payload: mostly back-to-back MBAP records with random content,
  // some spoiled in one way, the rest plain noise.
  task automatic build_random_payload();
    int nrec, n, idx;
    logic [15:0] len, tid;
    logic [7:0] func;
    pl_data = {};
    pl_jitter = 1'b0;
    if ($urandom_range(0, 9) < 7) begin
      nrec = $urandom_range(1, 4);
      for (int r = 0; r < nrec; r++) begin
        len = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(3, 40)) : 16'($urandom_range(3, 8));
        tid = 16'($urandom);
        func = 8'($urandom_range(1, 255));
        push_u16(tid);
        push_u16(16'h0000);
        push_u16(len);
        pl_data.push_back(8'($urandom));                 // unit id
        pl_data.push_back(func);
        pl_data.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(1, 12)));
        for (int j = 3; j < len; j++) pl_data.push_back(8'($urandom));
        if (r == 0) pl_fpl = 16'(pl_data.size());
      end
      pl_size = 16'(pl_data.size());
      pl_tcp = 1'b1;
      case ($urandom_range(0, 13))
        0: pl_tcp = 1'b0;
        1: pl_fpl = 16'($urandom);
        2: pl_size = 16'($urandom);
        3: pl_data[$urandom_range(0, pl_data.size() - 1)] = 8'($urandom);
        4: begin
          // trailing junk, counted in the size or not
          repeat ($urandom_range(1, 8)) pl_data.push_back(8'($urandom));
          if ($urandom_range(0, 1)) pl_size = 16'(pl_data.size());
        end
        5: begin
          // payload cut short, possibly mid-record
          n = $urandom_range(1, pl_data.size());
          while (pl_data.size() > n) void'(pl_data.pop_back());
          if ($urandom_range(0, 1)) pl_size = 16'(pl_data.size());
        end
        6: begin
          // transaction id equal to first packet length
          pl_data[0] = pl_fpl[15:8];
          pl_data[1] = pl_fpl[7:0];
        end
        7, 8: begin
          // LDAP-style lead bytes, probe byte (if inside the payload) set to the integer tag half the time
          pl_data[0] = mbtcp_pkg::LDAP_TID_MATCH[15:8];
          pl_data[1] = 8'h80 | 8'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 127 : 12));
          idx = (pl_data[1] & PROBE_LEN_MASK) + mbtcp_pkg::PROBE_OFFSET;
          if (idx < pl_data.size() && $urandom_range(0, 1))
            pl_data[idx] = mbtcp_pkg::BER_INTEGER_TAG;
        end
        9: pl_data[2 + $urandom_range(0, 1)] = 8'($urandom_range(1, 255));  // protocol id
        10: pl_data[4 + $urandom_range(0, 1)] = 8'($urandom);                // length field
        default: ;
      endcase
    end else begin
      n = $urandom_range(1, 24);
      repeat (n) pl_data.push_back(8'($urandom));
      pl_size = $urandom_range(0, 1) ? 16'(n) : 16'($urandom);
      pl_fpl = $urandom_range(0, 1) ? 16'($urandom_range(0, n)) : 16'($urandom);
      pl_tcp = 1'($urandom);
      pl_jitter = ($urandom_range(0, 3) == 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows[$];

  task automatic add_row(input int n, input logic [159:0] bytes, input logic [15:0] size,
                         input logic [15:0] fpl, input logic tcp, input bit pinned,
                         input logic rec, input logic [mbtcp_pkg::COUNT_BITS-1:0] cnt);
    dir_row_t row;
    row.n = n;
    row.bytes = bytes;
    row.size = size;
    row.fpl = fpl;
    row.tcp = tcp;
    row.pinned = pinned;
    row.want.recognized = rec;
    row.want.records = cnt;
    dir_rows.push_back(row);
  endtask

  initial begin : stimulus
    logic [15:0] limits [0:5];

    rst <= 1'b1;
    in_valid <= 1'b0;
    payload_byte <= '0;
    is_last <= 1'b0;
    payload_size <= '0;
    first_packet_length <= '0;
    is_tcp <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    mismatches = 0;
    payloads_done = 0;
    payloads_sent = 0;
    bytes_sent = 0;
    calm = 1'b0;
    foreach (pin_set[i]) pin_set[i] = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    //      n   bytes                                               size      fpl  tcp pin rec cnt
    // single good record, limit at its reset value
    add_row(9,  72'h1234_0000_0003_01_03_0A,                        16'd9,    16'd9,   1, 1, 1, 1);
    // not TCP
    add_row(9,  72'h1234_0000_0003_01_03_0A,                        16'd9,    16'd9,   0, 1, 0, 0);
    // one-byte payload
    add_row(1,  8'h00,                                              16'd1,    16'd0,   1, 1, 0, 0);
    // two records back to back
    add_row(19, 152'h0001_0000_0003_11_05_AA_0002_0000_0004_11_06_0001,
                                                                    16'd19,   16'd9,   1, 0, 0, 0);
    // first packet over the limit
    add_row(9,  72'h1234_0000_0003_01_03_0A,                        16'd9,    16'd261, 1, 1, 0, 0);
    // transaction id equals first packet length
    add_row(9,  72'h0009_0000_0003_01_03_0A,                        16'd9,    16'd9,   1, 1, 0, 0);
    // LDAP lead with the integer tag at the probed byte
    add_row(9,  72'h3084_0000_0003_02_03_0A,                        16'd9,    16'd9,   1, 1, 0, 0);
    // LDAP lead, probed byte is something else
    add_row(9,  72'h3084_0000_0003_01_03_0A,                        16'd9,    16'd9,   1, 0, 0, 0);
    // LDAP lead, probe index past the payload size
    add_row(9,  72'h30FF_0000_0003_01_03_0A,                        16'd9,    16'd9,   1, 0, 0, 0);
    // nonzero protocol id
    add_row(9,  72'h1234_0001_0003_01_03_0A,                        16'd9,    16'd9,   1, 1, 0, 0);
    // MBAP length under three
    add_row(9,  72'h1234_0000_0002_01_03_0A,                        16'd9,    16'd8,   1, 1, 0, 0);
    // record runs past the payload
    add_row(9,  72'h1234_0000_0004_01_03_0A,                        16'd9,    16'd10,  1, 1, 0, 0);
    // first record length disagrees with first packet
    add_row(9,  72'h1234_0000_0003_01_03_0A,                        16'd9,    16'd12,  1, 1, 0, 0);
    // exception with code zero, code thirteen, code twelve
    add_row(9,  72'h1234_0000_0003_01_83_00,                        16'd9,    16'd9,   1, 1, 0, 0);
    add_row(9,  72'h1234_0000_0003_01_83_0D,                        16'd9,    16'd9,   1, 1, 0, 0);
    add_row(9,  72'h1234_0000_0003_01_83_0C,                        16'd9,    16'd9,   1, 0, 0, 0);
    // all-ones bytes around the highest plain function code
    add_row(9,  72'hFFFF_0000_0003_FF_7F_FF,                        16'd9,    16'd9,   1, 0, 0, 0);
    // ends inside the second record's header
    add_row(14, 112'h1234_0000_0003_01_03_0A_1235_0000_00,          16'd14,   16'd9,   1, 0, 0, 0);
    // size field at its maximum
    add_row(9,  72'h1234_0000_0003_01_03_0A,                        16'hFFFF, 16'd9,   1, 0, 0, 0);
    // bytes beyond payload_size
    add_row(12, 96'h1234_0000_0003_01_03_0A_AB_CD_EF,               16'd9,    16'd9,   1, 0, 0, 0);
    // size under nine
    add_row(9,  72'h1234_0000_0003_01_03_0A,                        16'd8,    16'd9,   1, 1, 0, 0);

    foreach (dir_rows[r]) begin
      pl_data = {};
      for (int i = 0; i < dir_rows[r].n; i++)
        pl_data.push_back(dir_rows[r].bytes[8 * (dir_rows[r].n - 1 - i) +: 8]);
      pl_size = dir_rows[r].size;
      pl_fpl = dir_rows[r].fpl;
      pl_tcp = dir_rows[r].tcp;
      pl_jitter = 1'b0;
      if (dir_rows[r].pinned && payloads_sent < PIN_SLOTS) begin
        pin_val[payloads_sent] = dir_rows[r].want;
        pin_set[payloads_sent] = 1'b1;
      end
      send_payload();
    end

    // Random phases, each under its own first packet limit. Every limit
    // change waits for an idle block, which also gives full sender pauses.
    limits = '{16'd260, 16'd0, 16'hFFFF, 16'd9, 16'($urandom_range(10, 300)), 16'd260};
    foreach (limits[k]) begin
      set_fp_limit(limits[k]);
      bytes_sent = 0;
      while (bytes_sent < PHASE_BYTES) begin
        build_random_payload();
        send_payload();
        if ($urandom_range(0, 19) == 0) drain();
      end
    end

    drain();
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
